// ----- rtl/dsgm_pkg.sv -----
// Shared widths, sector codes, stage record and arithmetic helpers of the disk-to-square map.
`default_nettype none
package dsgm_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_STAGES = 16;

  // Fraction bits added to the radius, and to the rotation vector ahead of the CORDIC.
  localparam int RAD_GUARD   = 8;
  localparam int CORDIC_GUARD_BITS = 16;
  // Angle units: pi/4 equals 2^ANG_FRAC.
  localparam int ANG_FRAC    = 20;

  localparam int RT_BITS     = COORD_WIDTH + RAD_GUARD;
  localparam int REM_W       = RT_BITS + 3;
  localparam int NSQ_W       = 2 * COORD_WIDTH;
  localparam int PQ_W        = COORD_WIDTH + 1;
  localparam int CR_W        = PQ_W + CORDIC_GUARD_BITS + 2;
  localparam int Z_W         = ANG_FRAC + 3;
  localparam int ZC_W        = ANG_FRAC + 2;
  localparam int PROD_W      = ZC_W + RT_BITS + 1;
  localparam int M_W         = RT_BITS + 2;
  localparam int A_W         = RT_BITS + 3;

  localparam int SQ_PER_STAGE = 2;
  localparam int SQ_STAGES    = (RT_BITS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
  localparam int CORE_STAGES  = (ANGLE_STAGES > SQ_STAGES) ? ANGLE_STAGES : SQ_STAGES;

  localparam logic signed [Z_W-1:0] ANG_POS = Z_W'(64'd1 << ANG_FRAC);
  localparam logic signed [Z_W-1:0] ANG_NEG = -ANG_POS;
  localparam logic signed [PROD_W-1:0] M_RND = PROD_W'(64'd1 << (ANG_FRAC - 1));

  localparam logic signed [A_W:0] GRID_BIAS =
    (A_W+1)'((64'd1 << (COORD_WIDTH - 2 + RAD_GUARD)) + (64'd1 << (RAD_GUARD - 1)));
  localparam logic signed [A_W:0] GRID_TOP_S = (A_W+1)'(64'd1 << (COORD_WIDTH - 1));
  localparam logic [COORD_WIDTH-1:0] GRID_TOP = COORD_WIDTH'(64'd1 << (COORD_WIDTH - 1));

  // Quarter sectors, counterclockwise from the positive x axis.
  localparam logic [1:0] SEC_E = 2'd0;
  localparam logic [1:0] SEC_N = 2'd1;
  localparam logic [1:0] SEC_W = 2'd2;
  localparam logic [1:0] SEC_S = 2'd3;

  typedef struct packed {
    logic [NSQ_W-1:0]        nsh;
    logic [REM_W-1:0]        rem;
    logic [RT_BITS-1:0]      root;
    logic signed [CR_W-1:0]  p;
    logic signed [CR_W-1:0]  q;
    logic signed [Z_W-1:0]   z;
    logic [1:0]              sector;
  } core_data_t;

  // Arctangent of 2^-i in units where pi/4 is 2^20, rounded.
  function automatic logic [Z_W-1:0] atan_entry(input int i);
    logic [Z_W-1:0] v;
    case (i)
      0:  v = Z_W'(1048576);
      1:  v = Z_W'(619011);
      2:  v = Z_W'(327068);
      3:  v = Z_W'(166025);
      4:  v = Z_W'(83335);
      5:  v = Z_W'(41708);
      6:  v = Z_W'(20859);
      7:  v = Z_W'(10430);
      8:  v = Z_W'(5215);
      9:  v = Z_W'(2608);
      10: v = Z_W'(1304);
      11: v = Z_W'(652);
      12: v = Z_W'(326);
      13: v = Z_W'(163);
      14: v = Z_W'(81);
      15: v = Z_W'(41);
      16: v = Z_W'(20);
      17: v = Z_W'(10);
      18: v = Z_W'(5);
      19: v = Z_W'(3);
      20: v = Z_W'(1);
      21: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // One digit of the restoring square root; the radicand shifts out at the top.
  function automatic core_data_t sqrt_digit(input core_data_t d);
    core_data_t         o;
    logic [REM_W-1:0]   rem_s;
    logic [REM_W-1:0]   trial;
    o     = d;
    rem_s = {d.rem[REM_W-3:0], d.nsh[NSQ_W-1 -: 2]};
    trial = REM_W'({d.root, 2'b01});
    if (rem_s >= trial) begin
      o.rem  = rem_s - trial;
      o.root = {d.root[RT_BITS-2:0], 1'b1};
    end else begin
      o.rem  = rem_s;
      o.root = {d.root[RT_BITS-2:0], 1'b0};
    end
    o.nsh = {d.nsh[NSQ_W-3:0], 2'b00};
    return o;
  endfunction

  // Offset by one half, round halves up, drop the guard bits and saturate to [0, 1].
  function automatic logic [COORD_WIDTH-1:0] to_grid(input logic signed [A_W-1:0] a);
    logic signed [A_W:0] t;
    logic signed [A_W:0] s;
    logic [COORD_WIDTH-1:0] g;
    t = (A_W+1)'(a) + GRID_BIAS;
    s = t >>> RAD_GUARD;
    if (s < 0) begin
      g = '0;
    end else if (s > GRID_TOP_S) begin
      g = GRID_TOP;
    end else begin
      g = s[COORD_WIDTH-1:0];
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dsgm_if.sv -----
// Valid/ready channel interfaces for disk points and grid coordinates.
`default_nettype none
interface dsgm_in_if;
  import dsgm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] disk_x;
  logic signed [COORD_WIDTH-1:0] disk_y;
  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink (input valid, input disk_x, input disk_y, output ready);
endinterface

interface dsgm_out_if;
  import dsgm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] grid_u;
  logic [COORD_WIDTH-1:0] grid_v;
  modport source (output valid, output grid_u, output grid_v, input ready);
  modport sink (input valid, input grid_u, input grid_v, output ready);
endinterface
`default_nettype wire

// ----- rtl/disk_to_square_grid_map_top.sv -----
// Top level of the disk-to-square grid map: front end, core pipeline, scaling and output.
// Throughput: one transaction per cycle while the output register is not stalled;
// the unrolled CORDIC and root stages set the depth.
// Backpressure: a stalled output register freezes every stage, nothing is dropped or repeated.
// Reset: synchronous, active low rst_n clears all valid bits; payload registers keep data.
`default_nettype none
module disk_to_square_grid_map_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dsgm_in_if.sink    in_ch,
  dsgm_out_if.source out_ch
);
  import dsgm_pkg::*;

  // The whole pipeline advances together. It moves whenever the output register is
  // empty or its result is being taken in this cycle, so an item can enter every cycle.
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: squares of both coordinates, sector choice and the turn into the first sector.
  // A point on a sector border belongs to the sector that starts at that angle.
  logic signed [PQ_W-1:0]  xs;
  logic signed [PQ_W-1:0]  ys;
  logic signed [NSQ_W-1:0] x2_s;
  logic signed [NSQ_W-1:0] y2_s;
  logic [1:0]              sec_nxt;
  logic signed [PQ_W-1:0]  p_nxt;
  logic signed [PQ_W-1:0]  q_nxt;

  logic                    a_vld_r;
  logic [NSQ_W-1:0]        a_x2_r;
  logic [NSQ_W-1:0]        a_y2_r;
  logic [1:0]              a_sec_r;
  logic signed [PQ_W-1:0]  a_p_r;
  logic signed [PQ_W-1:0]  a_q_r;

  always_comb begin
    xs   = PQ_W'(in_ch.disk_x);
    ys   = PQ_W'(in_ch.disk_y);
    x2_s = NSQ_W'(in_ch.disk_x) * NSQ_W'(in_ch.disk_x);
    y2_s = NSQ_W'(in_ch.disk_y) * NSQ_W'(in_ch.disk_y);
    if (xs > 0 && ys < xs && ys >= -xs) begin
      sec_nxt = SEC_E;
      p_nxt   = xs;
      q_nxt   = ys;
    end else if (ys > 0 && xs <= ys && xs > -ys) begin
      sec_nxt = SEC_N;
      p_nxt   = ys;
      q_nxt   = -xs;
    end else if (xs < 0 && ys > xs && ys <= -xs) begin
      sec_nxt = SEC_W;
      p_nxt   = -xs;
      q_nxt   = -ys;
    end else begin
      sec_nxt = SEC_S;
      p_nxt   = -ys;
      q_nxt   = xs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x2_r  <= NSQ_W'(x2_s);
      a_y2_r  <= NSQ_W'(y2_s);
      a_sec_r <= sec_nxt;
      a_p_r   <= p_nxt;
      a_q_r   <= q_nxt;
    end
  end

  // Stage B: squared radius, and the rotation vector scaled up by the CORDIC guard bits.
  logic       b_vld_r;
  core_data_t b_dat_r;
  core_data_t b_dat_nxt;

  always_comb begin
    b_dat_nxt.nsh    = a_x2_r + a_y2_r;
    b_dat_nxt.rem    = '0;
    b_dat_nxt.root   = '0;
    b_dat_nxt.p      = CR_W'($signed({a_p_r, {CORDIC_GUARD_BITS{1'b0}}}));
    b_dat_nxt.q      = CR_W'($signed({a_q_r, {CORDIC_GUARD_BITS{1'b0}}}));
    b_dat_nxt.z      = '0;
    b_dat_nxt.sector = a_sec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dat_r <= b_dat_nxt;
    end
  end

  // Core: the angle offset and the radius are found side by side, stage for stage.
  logic       core_vld;
  core_data_t core_dat;

  dsgm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (b_vld_r),
    .dat_in  (b_dat_r),
    .vld_out (core_vld),
    .dat_out (core_dat)
  );

  // Stage M: clamp the angle offset to one sector width and multiply it by the radius.
  logic signed [Z_W-1:0]    z_cl;
  logic signed [PROD_W-1:0] prod_nxt;

  logic                     m_vld_r;
  logic signed [PROD_W-1:0] m_prod_r;
  logic [RT_BITS-1:0]       m_root_r;
  logic [1:0]               m_sec_r;

  always_comb begin
    if (core_dat.z > ANG_POS) begin
      z_cl = ANG_POS;
    end else if (core_dat.z < ANG_NEG) begin
      z_cl = ANG_NEG;
    end else begin
      z_cl = core_dat.z;
    end
    prod_nxt = PROD_W'($signed(z_cl[ZC_W-1:0])) * PROD_W'($signed({1'b0, core_dat.root}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= core_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod_r <= prod_nxt;
      m_root_r <= core_dat.root;
      m_sec_r  <= core_dat.sector;
    end
  end

  // Output stage: round the product, place radius and offset by sector, then offset,
  // round and saturate both coordinates into the unit square.
  logic signed [PROD_W-1:0] m_rnd;
  logic signed [M_W-1:0]    m_val;
  logic signed [A_W-1:0]    m_ext;
  logic signed [A_W-1:0]    rf_ext;
  logic signed [A_W-1:0]    a_val;
  logic signed [A_W-1:0]    b_val;

  logic                     out_vld_r;
  logic [COORD_WIDTH-1:0]   out_u_r;
  logic [COORD_WIDTH-1:0]   out_v_r;

  always_comb begin
    m_rnd  = (m_prod_r + M_RND) >>> ANG_FRAC;
    m_val  = m_rnd[M_W-1:0];
    m_ext  = A_W'(m_val);
    rf_ext = $signed(A_W'(m_root_r));
    case (m_sec_r)
      SEC_E: begin
        a_val = rf_ext;
        b_val = m_ext;
      end
      SEC_N: begin
        a_val = -m_ext;
        b_val = rf_ext;
      end
      SEC_W: begin
        a_val = -rf_ext;
        b_val = -m_ext;
      end
      default: begin
        a_val = m_ext;
        b_val = -rf_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_u_r <= to_grid(a_val);
      out_v_r <= to_grid(b_val);
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.grid_u = out_u_r;
  assign out_ch.grid_v = out_v_r;

  // Reset empties the output register on the following edge.
  a_rst_empties: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // A stalled pipeline keeps the valid bit of the core's last stage exactly where it was.
  a_stall_holds_core: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(core_vld))
    else $error("core moved while the pipeline was stalled");

  // Saturation keeps both coordinates inside the unit square.
  a_grid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.grid_u <= GRID_TOP) && (out_ch.grid_v <= GRID_TOP))
    else $error("grid coordinate above one");

endmodule
`default_nettype wire

// ----- rtl/dsgm_core.sv -----
// Unrolled core: one CORDIC step per stage, two root digits per stage until all are done.
`default_nettype none
module dsgm_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire dsgm_pkg::core_data_t dat_in,
  output logic                    vld_out,
  output dsgm_pkg::core_data_t    dat_out
);
  import dsgm_pkg::*;

  logic       vld_r [CORE_STAGES];
  core_data_t dat_r [CORE_STAGES];

  for (genvar j = 0; j < CORE_STAGES; j++) begin : g_stg
    core_data_t src;
    core_data_t dat_nxt;
    logic       src_vld;

    if (j == 0) begin : g_first
      assign src     = dat_in;
      assign src_vld = vld_in;
    end else begin : g_next
      assign src     = dat_r[j-1];
      assign src_vld = vld_r[j-1];
    end

    always_comb begin
      dat_nxt = src;
      if (j < ANGLE_STAGES) begin
        // Rotate toward the x axis, steering by the sign of q.
        if (!src.q[CR_W-1]) begin
          dat_nxt.p = src.p + ($signed(src.q) >>> j);
          dat_nxt.q = src.q - ($signed(src.p) >>> j);
          dat_nxt.z = src.z + atan_entry(j);
        end else begin
          dat_nxt.p = src.p - ($signed(src.q) >>> j);
          dat_nxt.q = src.q + ($signed(src.p) >>> j);
          dat_nxt.z = src.z - atan_entry(j);
        end
      end
      for (int d = 0; d < SQ_PER_STAGE; d++) begin
        if (j * SQ_PER_STAGE + d < RT_BITS) begin
          dat_nxt = sqrt_digit(dat_nxt);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dat_r[j] <= dat_nxt;
      end
    end
  end

  assign vld_out = vld_r[CORE_STAGES-1];
  assign dat_out = dat_r[CORE_STAGES-1];

endmodule
`default_nettype wire

// ----- verif/tb_disk_to_square_grid_map_top.sv -----
// Self-checking testbench of the disk-to-square grid map: directed table, random points, scoreboard.
`default_nettype none
module tb_disk_to_square_grid_map_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsgm_pkg::*;

  // Grid value for one half, the image of a zero coordinate.
  localparam logic [COORD_WIDTH-1:0] GRID_HALF = COORD_WIDTH'(1 << (COORD_WIDTH - 2));
  localparam int N_DIRECTED    = 24;
  localparam int N_RANDOM      = 450;
  localparam int DRAIN_CYCLES  = 40;
  // Receiver schedule, in cycles after reset: a calm window without any stall,
  // then a long hold-off that fills the pipeline and stalls the input side.
  localparam int CALM_START    = 60;
  localparam int CALM_END      = 220;
  localparam int HOLD_START    = 300;
  localparam int HOLD_END      = 480;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          typed;
    logic [COORD_WIDTH-1:0]        u;
    logic [COORD_WIDTH-1:0]        v;
  } point_row_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0]        u;
    logic [COORD_WIDTH-1:0]        v;
  } grid_expect_t;

  logic clk;
  logic rst_n;
  int   fail_count;

  grid_expect_t grid_expect_q[$];

  dsgm_in_if  in_ch ();
  dsgm_out_if out_ch ();

  disk_to_square_grid_map_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The directed table. Expected values are typed in only where they are plain:
  // the origin maps to the center, and the far corners of the input range lie
  // well outside the unit disk, so both coordinates saturate. Every other row,
  // including the sector borders and the axes, goes through the predictor.
  point_row_t directed_rows [N_DIRECTED] = '{
    '{16'sd0,      16'sd0,      1'b1, GRID_HALF, GRID_HALF},
    '{16'sd32767,  16'sd32767,  1'b1, GRID_TOP,  GRID_TOP},
    '{16'sh8000,   16'sh8000,   1'b1, 16'd0,     16'd0},
    '{16'sd32767,  16'sh8000,   1'b1, GRID_TOP,  16'd0},
    '{16'sh8000,   16'sd32767,  1'b1, 16'd0,     GRID_TOP},
    '{16'sd16384,  16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      16'sd16384,  1'b0, 16'd0,     16'd0},
    '{-16'sd16384, 16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      -16'sd16384, 1'b0, 16'd0,     16'd0},
    '{16'sd8192,   16'sd8192,   1'b0, 16'd0,     16'd0},
    '{16'sd8192,   -16'sd8192,  1'b0, 16'd0,     16'd0},
    '{-16'sd8192,  16'sd8192,   1'b0, 16'd0,     16'd0},
    '{-16'sd8192,  -16'sd8192,  1'b0, 16'd0,     16'd0},
    '{16'sd1,      16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      16'sd1,      1'b0, 16'd0,     16'd0},
    '{-16'sd1,     16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      -16'sd1,     1'b0, 16'd0,     16'd0},
    '{16'sh8000,   16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      16'sh8000,   1'b0, 16'd0,     16'd0},
    '{16'sd32767,  16'sd0,      1'b0, 16'd0,     16'd0},
    '{16'sd0,      16'sd32767,  1'b0, 16'd0,     16'd0},
    '{16'sd11585,  16'sd11585,  1'b0, 16'd0,     16'd0},
    '{16'sd12000,  -16'sd5000,  1'b0, 16'd0,     16'd0},
    '{-16'sd3000,  16'sd14000,  1'b0, 16'd0,     16'd0}
  };

  // Step angle of CORDIC stage i, in units where pi/4 is 2^20.
  function automatic longint arctan_step(input int i);
    real ratio;
    ratio = $atan(1.0 / (2.0 ** i)) / $atan(1.0);
    return longint'(ratio * 1048576.0);
  endfunction

  // Floor of the square root of n, found bit by bit from the top.
  function automatic longint isqrt(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Center, round and clamp one square coordinate onto the grid.
  function automatic logic [COORD_WIDTH-1:0] grid_coord(input longint a);
    longint g;
    g = ((longint'(1) << (COORD_WIDTH - 2 + RAD_GUARD)) + a +
         (longint'(1) << (RAD_GUARD - 1))) >>> RAD_GUARD;
    if (g < 0) begin
      g = 0;
    end
    if (g > (longint'(1) << (COORD_WIDTH - 1))) begin
      g = longint'(1) << (COORD_WIDTH - 1);
    end
    return g[COORD_WIDTH-1:0];
  endfunction

  // Maps one disk point to its grid cell. The radius carries RAD_GUARD extra
  // fraction bits. The point is turned into the east sector, a CORDIC finds its
  // angle from the sector axis, and that angle times the radius is the second
  // square coordinate.
  function automatic grid_expect_t map_disk_point(input logic signed [COORD_WIDTH-1:0] px,
                                                  input logic signed [COORD_WIDTH-1:0] py);
    grid_expect_t e;
    longint x, y, p, q, dp, dq, z, radius, m, a, b;
    logic [1:0] sector;
    x = longint'(px);
    y = longint'(py);
    radius = isqrt((x * x + y * y) << (2 * RAD_GUARD));
    // A point on a border belongs to the sector that starts there.
    if (x > 0 && y < x && y >= -x) begin
      sector = SEC_E; p = x;  q = y;
    end else if (y > 0 && x <= y && x > -y) begin
      sector = SEC_N; p = y;  q = -x;
    end else if (x < 0 && y > x && y <= -x) begin
      sector = SEC_W; p = -x; q = -y;
    end else begin
      sector = SEC_S; p = -y; q = x;
    end
    p = p <<< CORDIC_GUARD_BITS;
    q = q <<< CORDIC_GUARD_BITS;
    z = 0;
    for (int i = 0; i < ANGLE_STAGES; i++) begin
      dp = q >>> i;
      dq = p >>> i;
      if (q >= 0) begin
        p = p + dp; q = q - dq; z = z + arctan_step(i);
      end else begin
        p = p - dp; q = q + dq; z = z - arctan_step(i);
      end
    end
    if (z > (longint'(1) << ANG_FRAC)) begin
      z = longint'(1) << ANG_FRAC;
    end
    if (z < -(longint'(1) << ANG_FRAC)) begin
      z = -(longint'(1) << ANG_FRAC);
    end
    m = (z * radius + (longint'(1) << (ANG_FRAC - 1))) >>> ANG_FRAC;
    case (sector)
      SEC_E:   begin a = radius;  b = m;       end
      SEC_N:   begin a = -m;      b = radius;  end
      SEC_W:   begin a = -radius; b = -m;      end
      default: begin a = m;       b = -radius; end
    endcase
    e.x = px;
    e.y = py;
    e.u = grid_coord(a);
    e.v = grid_coord(b);
    return e;
  endfunction

  // Random point. Most points fall inside the unit disk, where no coordinate
  // saturates; the rest cover the whole input range, the sector borders and
  // the neighborhood of the origin.
  task automatic pick_point(output logic signed [COORD_WIDTH-1:0] px,
                            output logic signed [COORD_WIDTH-1:0] py);
    int mode;
    int base;
    int delta;
    mode = $urandom_range(99);
    if (mode < 55) begin
      px = COORD_WIDTH'(int'($urandom_range(32768)) - 16384);
      py = COORD_WIDTH'(int'($urandom_range(32768)) - 16384);
    end else if (mode < 75) begin
      px = COORD_WIDTH'($urandom);
      py = COORD_WIDTH'($urandom);
    end else if (mode < 90) begin
      base  = int'($urandom_range(32000)) - 16000;
      delta = int'($urandom_range(4)) - 2;
      px = COORD_WIDTH'(base);
      py = ($urandom_range(1) != 0) ? COORD_WIDTH'(base + delta) : COORD_WIDTH'(delta - base);
    end else begin
      px = COORD_WIDTH'(int'($urandom_range(16)) - 8);
      py = COORD_WIDTH'(int'($urandom_range(16)) - 8);
    end
  endtask

  // Offers one point and holds it until the block takes it. The expectation
  // is queued at the accepting edge.
  task automatic send_point(input logic signed [COORD_WIDTH-1:0] px,
                            input logic signed [COORD_WIDTH-1:0] py,
                            input logic typed,
                            input logic [COORD_WIDTH-1:0] typed_u,
                            input logic [COORD_WIDTH-1:0] typed_v);
    grid_expect_t e;
    in_ch.valid  <= 1'b1;
    in_ch.disk_x <= px;
    in_ch.disk_y <= py;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      e.x = px;
      e.y = py;
      e.u = typed_u;
      e.v = typed_v;
    end else begin
      e = map_disk_point(px, py);
    end
    grid_expect_q = {grid_expect_q, e};
  endtask

  // Random one-cycle gap on the input side; valid only drops when a gap is taken.
  task automatic maybe_pause(input bit calm);
    if (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset and stimulus. After reset, the directed table is walked, then
  // the random points follow, with a calm stretch in the middle where the
  // sender leaves no gaps.
  initial begin
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.disk_x = '0;
    in_ch.disk_y = '0;
    fail_count   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
                 directed_rows[i].u, directed_rows[i].v);
      maybe_pause(1'b0);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      pick_point(px, py);
      send_point(px, py, 1'b0, '0, '0);
      maybe_pause(i >= 150 && i < 250);
    end
    in_ch.valid <= 1'b0;

    // Wait for the pipeline to deliver everything, then a little longer so a
    // spurious extra result would still be caught.
    while (grid_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side ready. The cycle count starts at reset release; it selects a
  // calm window, a long hold-off while the sender keeps offering, and random
  // stalls everywhere else.
  initial begin
    int cycle;
    out_ch.ready = 1'b0;
    cycle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cycle >= HOLD_START && cycle < HOLD_END) begin
        out_ch.ready <= 1'b0;
      end else if (cycle >= CALM_START && cycle < CALM_END) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 11);
      end
      @(posedge clk);
      cycle++;
    end
  end

  // Scoreboard. Each result transaction is compared with the oldest expected
  // grid cell, one field at a time.
  always @(posedge clk) begin
    grid_expect_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (grid_expect_q.size() == 0) begin
        fail_count++;
        $display("%t: result with none expected: got u=%0d v=%0d",
                 $time, out_ch.grid_u, out_ch.grid_v);
      end else begin
        e = grid_expect_q.pop_front();
        if (out_ch.grid_u !== e.u) begin
          fail_count++;
          $display("%t: point (%0d,%0d) grid_u: expected %0d, got %0d",
                   $time, e.x, e.y, e.u, out_ch.grid_u);
        end
        if (out_ch.grid_v !== e.v) begin
          fail_count++;
          $display("%t: point (%0d,%0d) grid_v: expected %0d, got %0d",
                   $time, e.x, e.y, e.v, out_ch.grid_v);
        end
      end
    end
  end

  // Watchdog: a run that has not finished by the time limit is failed.
  initial begin
    #500us;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
